/* rtl/mra_pkg.sv */
// Shared constants, types and codes of the multi-resource allocator.
package mra_pkg;

    localparam int MAX_TASKS   = 32;
    localparam int NUM_POOLS   = 4;
    localparam int AMOUNT_BITS = 16;

    localparam int POOL_SLOTS = 4;
    localparam int FIELD_W    = 16;
    localparam int TASK_ID_W  = 5;
    localparam int TASK_AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int HOLD_W     = NUM_POOLS * AMOUNT_BITS;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    localparam logic [FIELD_W-1:0] RUN_MAX = '1;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_IDLE = 2'd2
    } mode_t;

    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } act_t;

    typedef enum logic [2:0] {
        REG_CAP0 = 3'd0,
        REG_CAP1 = 3'd1,
        REG_CAP2 = 3'd2,
        REG_CAP3 = 3'd3,
        REG_ITER = 3'd4
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctl_state_t;

    typedef struct packed {
        mode_t              mode;
        logic [FIELD_W-1:0] runs;
    } task_entry_t;

    localparam task_entry_t TASK_RESET = '{mode: MODE_IDLE, runs: '0};

    typedef struct packed {
        logic [POOL_SLOTS-1:0][FIELD_W-1:0] capacity;
        logic [FIELD_W-1:0]                 iterations;
    } cfg_t;

endpackage

/* rtl/mra_req_if.sv */
// Request channel: acquire/release beats into the allocator.
interface mra_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [mra_pkg::TASK_ID_W-1:0] task_id;
    logic [mra_pkg::FIELD_W-1:0]   need_pool0;
    logic [mra_pkg::FIELD_W-1:0]   need_pool1;
    logic [mra_pkg::FIELD_W-1:0]   need_pool2;
    logic [mra_pkg::FIELD_W-1:0]   need_pool3;

    modport source (
        output valid, action, task_id, need_pool0, need_pool1, need_pool2, need_pool3,
        input  ready
    );
    modport sink (
        input  valid, action, task_id, need_pool0, need_pool1, need_pool2, need_pool3,
        output ready
    );
endinterface

/* rtl/mra_res_if.sv */
// Result channel: one beat per request out of the allocator.
interface mra_res_if;
    logic                          valid;
    logic                          ready;
    logic [mra_pkg::TASK_ID_W-1:0] result_task;
    logic                          granted;
    logic [1:0]                    task_state;
    logic [mra_pkg::FIELD_W-1:0]   runs_done;
    logic                          task_finished;
    logic                          misuse;
    logic [mra_pkg::FIELD_W-1:0]   free_pool0;
    logic [mra_pkg::FIELD_W-1:0]   free_pool1;
    logic [mra_pkg::FIELD_W-1:0]   free_pool2;
    logic [mra_pkg::FIELD_W-1:0]   free_pool3;

    modport source (
        output valid, result_task, granted, task_state, runs_done, task_finished, misuse,
               free_pool0, free_pool1, free_pool2, free_pool3,
        input  ready
    );
    modport sink (
        input  valid, result_task, granted, task_state, runs_done, task_finished, misuse,
               free_pool0, free_pool1, free_pool2, free_pool3,
        output ready
    );
endinterface

/* rtl/mra_apb_regs.sv */
// APB configuration registers: pool capacities and iteration target.
module mra_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mra_pkg::APB_AW-1:0]  paddr,
    input  logic [mra_pkg::APB_DW-1:0]  pwdata,
    output logic [mra_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output mra_pkg::cfg_t               cfg
);
    import mra_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_CAP0: cfg_next.capacity[0] = pwdata[FIELD_W-1:0];
                REG_CAP1: cfg_next.capacity[1] = pwdata[FIELD_W-1:0];
                REG_CAP2: cfg_next.capacity[2] = pwdata[FIELD_W-1:0];
                REG_CAP3: cfg_next.capacity[3] = pwdata[FIELD_W-1:0];
                REG_ITER: cfg_next.iterations  = pwdata[FIELD_W-1:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CAP0: prdata = APB_DW'(cfg_reg.capacity[0]);
            REG_CAP1: prdata = APB_DW'(cfg_reg.capacity[1]);
            REG_CAP2: prdata = APB_DW'(cfg_reg.capacity[2]);
            REG_CAP3: prdata = APB_DW'(cfg_reg.capacity[3]);
            REG_ITER: prdata = APB_DW'(cfg_reg.iterations);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

/* rtl/mra_task_table.sv */
// Per-task mode and run count: synchronous RAM with per-entry valid bits.
module mra_task_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [mra_pkg::TASK_AW-1:0] rd_addr,
    output mra_pkg::task_entry_t        rd_data,
    input  logic                        wr_en,
    input  logic [mra_pkg::TASK_AW-1:0] wr_addr,
    input  mra_pkg::task_entry_t        wr_data
);
    import mra_pkg::*;

    task_entry_t                mem [MAX_TASKS];
    logic [MAX_TASKS-1:0]       valid_reg;
    task_entry_t                data_reg;
    logic                       hit_reg;

    // entries never written read back as the reset entry
    assign rd_data = hit_reg ? data_reg : TASK_RESET;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                hit_reg <= valid_reg[rd_addr];
        end
    end

endmodule

/* rtl/mra_hold_ram.sv */
// Per-task holdings of every pool: one row per task, registered read.
module mra_hold_ram (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [mra_pkg::TASK_AW-1:0] rd_addr,
    output logic [mra_pkg::HOLD_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [mra_pkg::TASK_AW-1:0] wr_addr,
    input  logic [mra_pkg::HOLD_W-1:0]  wr_data
);
    import mra_pkg::*;

    logic [HOLD_W-1:0] mem [MAX_TASKS];
    logic [HOLD_W-1:0] data_reg;

    assign rd_data = data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            data_reg <= mem[rd_addr];
    end

endmodule

/* rtl/multi_resource_allocator.sv */
// Multi-resource allocator top level: control, pool counters, result register.
//
// Usage:
//  req (sink): one beat per acquire or release naming a task and, for an
//    acquire, the units wanted from each of four pools. All-or-nothing: an
//    acquire is granted only if every pool can cover its need.
//  res (source): exactly one beat per request, in request order, carrying
//    grant, misuse flag, the task's mode, run count, finished flag and the
//    free units of every pool after the request.
//  APB: capacity of pools 0..3 at 0x00..0x0C, iterations target at 0x10.
//    Writes register at the access cycle's end; write only while idle.
// Sequence: the accept edge reads the task table and holdings RAM; the
//  update edge, once the result register is free, applies the update,
//  writes both RAMs back and loads the result register, which raises
//  result valid. A new request is taken only once the update of the
//  last one is done, set by the registered read of the task RAMs.
// Reset: all tasks idle with zero runs (per-entry valid bits, no clearing
//  pass), pools empty, registers zero; nothing needs initializing.
// Stall: a new request is taken while a result waits; the update stage
//  holds until the result register is free.
module multi_resource_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    mra_req_if.sink                     req,
    mra_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mra_pkg::APB_AW-1:0]  paddr,
    input  logic [mra_pkg::APB_DW-1:0]  pwdata,
    output logic [mra_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import mra_pkg::*;

    localparam int AW = AMOUNT_BITS;

    // configuration
    cfg_t cfg;

    // control
    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;
    logic       exec_fire;

    // captured request
    logic                                 item_action_reg;
    logic [TASK_ID_W-1:0]                 item_task_reg;
    logic [POOL_SLOTS-1:0][FIELD_W-1:0]   item_need_reg;

    // pool usage
    logic [AW-1:0] in_use_reg  [NUM_POOLS];
    logic [AW-1:0] in_use_next [NUM_POOLS];

    // RAM ports
    task_entry_t        ent_rd;
    task_entry_t        ent_new;
    logic               task_wr;
    logic [HOLD_W-1:0]  hold_rd;
    logic [HOLD_W-1:0]  hold_wdata;
    logic               hold_wr;
    logic [TASK_AW-1:0] rd_addr;
    logic [TASK_AW-1:0] exec_addr;

    // update datapath
    logic [AW-1:0]      need_amt [NUM_POOLS];
    logic [AW-1:0]      cap_amt  [NUM_POOLS];
    logic [AW-1:0]      free_old [NUM_POOLS];
    logic [AW-1:0]      held     [NUM_POOLS];
    logic [FIELD_W-1:0] free_new [POOL_SLOTS];
    logic               in_range;
    logic               fits;
    logic               fin_old;
    logic               fin_new;
    logic               granted_c;
    logic               misuse_c;

    // result register
    logic                                 out_valid_reg;
    logic [TASK_ID_W-1:0]                 out_task_reg;
    logic                                 out_granted_reg;
    logic [1:0]                           out_state_reg;
    logic [FIELD_W-1:0]                   out_runs_reg;
    logic                                 out_fin_reg;
    logic                                 out_misuse_reg;
    logic [POOL_SLOTS-1:0][FIELD_W-1:0]   out_free_reg;

    mra_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign rd_addr   = TASK_AW'(req.task_id);
    assign exec_addr = TASK_AW'(item_task_reg);

    mra_task_table u_tasks (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ent_rd),
        .wr_en   (task_wr),
        .wr_addr (exec_addr),
        .wr_data (ent_new)
    );

    mra_hold_ram u_hold (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (hold_rd),
        .wr_en   (hold_wr),
        .wr_addr (exec_addr),
        .wr_data (hold_wdata)
    );

    // ---------------- control FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold the update until the result register can take it
                exec_fire = !out_valid_reg || res.ready;
                if (exec_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign accept = req.valid & req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_action_reg  <= req.action;
            item_task_reg    <= req.task_id;
            item_need_reg[0] <= req.need_pool0;
            item_need_reg[1] <= req.need_pool1;
            item_need_reg[2] <= req.need_pool2;
            item_need_reg[3] <= req.need_pool3;
        end
    end

    // ---------------- update datapath ----------------
    always_comb
    begin
        in_range = (32'(item_task_reg) < MAX_TASKS);
        fin_old  = (cfg.iterations != '0) && (ent_rd.runs >= cfg.iterations);
        fits     = 1'b1;
        for (int p = 0; p < NUM_POOLS; p++)
        begin
            need_amt[p] = AW'(item_need_reg[p]);
            cap_amt[p]  = AW'(cfg.capacity[p]);
            held[p]     = hold_rd[p*AW +: AW];
            // capacity may sit below usage after a config change: saturate
            free_old[p] = (cap_amt[p] > in_use_reg[p]) ? cap_amt[p] - in_use_reg[p] : '0;
            if (need_amt[p] > free_old[p])
                fits = 1'b0;
            hold_wdata[p*AW +: AW] = need_amt[p];
            in_use_next[p] = in_use_reg[p];
        end

        ent_new   = ent_rd;
        granted_c = 1'b0;
        misuse_c  = 1'b0;
        task_wr   = 1'b0;
        hold_wr   = 1'b0;

        if (!in_range)
            misuse_c = 1'b1;
        else if (item_action_reg == ACT_ACQUIRE)
        begin
            if (ent_rd.mode == MODE_RUN || fin_old)
                misuse_c = 1'b1;
            else if (fits)
            begin
                granted_c    = 1'b1;
                ent_new.mode = MODE_RUN;
                task_wr      = exec_fire;
                hold_wr      = exec_fire;
                for (int p = 0; p < NUM_POOLS; p++)
                    in_use_next[p] = in_use_reg[p] + need_amt[p];
            end
            else
            begin
                ent_new.mode = MODE_WAIT;
                task_wr      = exec_fire;
            end
        end
        else
        begin
            if (ent_rd.mode != MODE_RUN)
                misuse_c = 1'b1;
            else
            begin
                ent_new.mode = MODE_IDLE;
                if (ent_rd.runs != RUN_MAX)
                    ent_new.runs = ent_rd.runs + 1'b1;
                task_wr = exec_fire;
                for (int p = 0; p < NUM_POOLS; p++)
                    in_use_next[p] = (in_use_reg[p] > held[p]) ? in_use_reg[p] - held[p] : '0;
            end
        end

        fin_new = (cfg.iterations != '0) && (ent_new.runs >= cfg.iterations);

        // pools beyond the configured count report nothing free
        for (int s = 0; s < POOL_SLOTS; s++)
            free_new[s] = '0;
        for (int p = 0; p < NUM_POOLS; p++)
            free_new[p] = FIELD_W'((cap_amt[p] > in_use_next[p]) ?
                                   cap_amt[p] - in_use_next[p] : AW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_POOLS; p++)
                in_use_reg[p] <= '0;
        end
        else if (exec_fire)
        begin
            for (int p = 0; p < NUM_POOLS; p++)
                in_use_reg[p] <= in_use_next[p];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_fire)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_task_reg    <= item_task_reg;
            out_granted_reg <= granted_c;
            out_misuse_reg  <= misuse_c;
            out_state_reg   <= in_range ? ent_new.mode : 2'd0;
            out_runs_reg    <= in_range ? ent_new.runs : '0;
            out_fin_reg     <= in_range & fin_new;
            for (int s = 0; s < POOL_SLOTS; s++)
                out_free_reg[s] <= free_new[s];
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.result_task   = out_task_reg;
    assign res.granted       = out_granted_reg;
    assign res.task_state    = out_state_reg;
    assign res.runs_done     = out_runs_reg;
    assign res.task_finished = out_fin_reg;
    assign res.misuse        = out_misuse_reg;
    assign res.free_pool0    = out_free_reg[0];
    assign res.free_pool1    = out_free_reg[1];
    assign res.free_pool2    = out_free_reg[2];
    assign res.free_pool3    = out_free_reg[3];

    // ---------------- assertions ----------------
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> res.valid)
        else $error("update completed without a result beat");

    a_grant_not_misuse: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.granted && res.misuse))
        else $error("result both granted and flagged misuse");

    a_grant_running: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.granted) |-> (res.task_state == MODE_RUN))
        else $error("granted task not reported running");

endmodule
